// File: design/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and constants of the reversible deque
// Ring store size, field widths, operation codes and slot arithmetic.
// ----------------------------------------------------------------------------
package rdq_pkg;

  // ring store geometry
  localparam int DEPTH  = 64;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int COUNT_OUT_W = 7;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS     = MODE_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * DATA_W + 1 + COUNT_OUT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REVERSE    = 3'd4
  } mode_t;

  // control states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // access request to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

  // ring index step forward, wrapping at DEPTH
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(DEPTH - 1)) r = '0;
    else r = s + SLOT_W'(1);
    return r;
  endfunction

  // ring index step backward, wrapping at DEPTH
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) r = SLOT_W'(DEPTH - 1);
    else r = s - SLOT_W'(1);
    return r;
  endfunction

endpackage

// File: design/rdq_ram.sv
// ----------------------------------------------------------------------------
// rdq_ram: entry store of the reversible deque
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rdq_ram (
  input  logic                      clk,
  input  rdq_pkg::ram_req_t         req,
  output logic [rdq_pkg::DATA_W-1:0] rd_data
);
  import rdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: design/reversible_deque_unit.sv
// ----------------------------------------------------------------------------
// reversible_deque_unit: bounded double-ended queue with a reverse flag
// Ring store in one synchronous RAM; end values cached in registers.
// ----------------------------------------------------------------------------
// Latency: result registered, valid in the cycle after accept; a pop that must
//   fetch the new end value from the RAM (more than two entries held) first
//   passes through ST_READ. Throughput: one transaction per cycle while the
//   result side takes results, but no new transaction is taken during ST_READ.
// Reset: rst (synchronous) empties the queue and clears orientation; the
//   entry store itself is not cleared.
module reversible_deque_unit (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: [2:0] mode, [34:3] push_value, [39:35] zero
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rdq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // m_tdata: [31:0] front_value, [63:32] back_value, [64] is_empty,
  //          [71:65] entry_count, [72] op_error, [79:73] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rdq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rdq_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - OUT_BITS;

  // control and end registers
  state_t            state, state_next;
  logic [SLOT_W-1:0] first_slot, first_slot_next;
  logic [SLOT_W-1:0] last_slot, last_slot_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              rev, rev_next;
  logic              err_pend, err_pend_next;
  logic              read_first, read_first_next;
  logic [DATA_W-1:0] first_val, first_val_next;
  logic [DATA_W-1:0] last_val, last_val_next;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] rd_data;

  mode_t             in_mode;
  logic [DATA_W-1:0] in_val;
  logic              out_free;
  logic              accept;
  logic              at_first;
  logic              err;
  logic              need_read;
  logic              load_out;
  logic [DATA_W-1:0] front_res, back_res;

  // input fields and handshake
  assign in_mode  = mode_t'(s_tdata[MODE_W-1:0]);
  assign in_val   = s_tdata[MODE_W +: DATA_W];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // physical end that the operation works on
  assign at_first = (in_mode == MODE_PUSH_FRONT || in_mode == MODE_POP_FRONT) ? !rev : rev;

  rdq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      first_slot <= '0;
      last_slot  <= '0;
      count      <= '0;
      rev        <= 1'b0;
      err_pend   <= 1'b0;
      read_first <= 1'b0;
    end else begin
      state      <= state_next;
      first_slot <= first_slot_next;
      last_slot  <= last_slot_next;
      count      <= count_next;
      rev        <= rev_next;
      err_pend   <= err_pend_next;
      read_first <= read_first_next;
    end
  end

  // cached end values
  always_ff @(posedge clk) begin
    first_val <= first_val_next;
    last_val  <= last_val_next;
  end

  // operation decode, ring update and sequencing
  always_comb begin
    state_next      = state;
    first_slot_next = first_slot;
    last_slot_next  = last_slot;
    count_next      = count;
    rev_next        = rev;
    err_pend_next   = err_pend;
    read_first_next = read_first;
    first_val_next  = first_val;
    last_val_next   = last_val;
    ram_req         = '0;
    err             = 1'b0;
    need_read       = 1'b0;
    load_out        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (count == CNT_W'(DEPTH)) begin
                err = 1'b1;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = in_val;
                if (count == '0) begin
                  last_slot_next  = first_slot;
                  ram_req.wr_addr = first_slot;
                  first_val_next  = in_val;
                  last_val_next   = in_val;
                end else if (at_first) begin
                  first_slot_next = slot_dec(first_slot);
                  ram_req.wr_addr = slot_dec(first_slot);
                  first_val_next  = in_val;
                end else begin
                  last_slot_next  = slot_inc(last_slot);
                  ram_req.wr_addr = slot_inc(last_slot);
                  last_val_next   = in_val;
                end
                count_next = count + CNT_W'(1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (count == '0) begin
                err = 1'b1;
              end else begin
                if (count > CNT_W'(1)) begin
                  if (at_first) begin
                    first_slot_next = slot_inc(first_slot);
                    if (count == CNT_W'(2)) begin
                      first_val_next = last_val;
                    end else begin
                      need_read       = 1'b1;
                      ram_req.rd_en   = 1'b1;
                      ram_req.rd_addr = slot_inc(first_slot);
                    end
                  end else begin
                    last_slot_next = slot_dec(last_slot);
                    if (count == CNT_W'(2)) begin
                      last_val_next = first_val;
                    end else begin
                      need_read       = 1'b1;
                      ram_req.rd_en   = 1'b1;
                      ram_req.rd_addr = slot_dec(last_slot);
                    end
                  end
                end
                count_next = count - CNT_W'(1);
              end
            end
            MODE_REVERSE: begin
              rev_next = !rev;
            end
            default: begin
            end
          endcase
          err_pend_next = err;
          if (need_read) begin
            state_next      = ST_READ;
            read_first_next = at_first;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_READ: begin
        // fetched end value lands when the output register is free
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (read_first) first_val_next = rd_data;
          else last_val_next = rd_data;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // logical end values after the operation
  always_comb begin
    if (count_next == '0) begin
      front_res = '1;
      back_res  = '1;
    end else if (rev_next) begin
      front_res = last_val_next;
      back_res  = first_val_next;
    end else begin
      front_res = first_val_next;
      back_res  = last_val_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{PAD_W{1'b0}},
                  (state == ST_READ) ? err_pend : err,
                  COUNT_OUT_W'(count_next),
                  count_next == '0,
                  back_res,
                  front_res};
    end
  end

endmodule

// File: design/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_port_checks: port-level checks for the reversible deque
// Watches the result stream for consistent empty, count and end values.
// ----------------------------------------------------------------------------
module rdq_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rdq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rdq_pkg::*;

  logic [DATA_W-1:0]      front_value;
  logic [DATA_W-1:0]      back_value;
  logic                   is_empty;
  logic [COUNT_OUT_W-1:0] entry_count;

  assign front_value = m_tdata[DATA_W-1:0];
  assign back_value  = m_tdata[2*DATA_W-1:DATA_W];
  assign is_empty    = m_tdata[2*DATA_W];
  assign entry_count = m_tdata[2*DATA_W+1 +: COUNT_OUT_W];

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // an empty queue reports -1 at both ends
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && is_empty |-> (front_value == '1) && (back_value == '1))
    else $error("empty queue reports stored values");

  // the count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (entry_count <= COUNT_OUT_W'(DEPTH)))
    else $error("entry count beyond ring size");

  // a single entry is both front and back
  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (entry_count == COUNT_OUT_W'(1)) |-> (front_value == back_value))
    else $error("single entry reports different ends");

endmodule

bind reversible_deque_unit rdq_port_checks u_rdq_checker (.*);

// File: tb/sv/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_checker: result checker for the reversible deque
// Watches both stream channels, keeps its own copy of the deque state, works
// out the expected front/back view for every accepted operation and compares
// each returned result with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rdq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // s_tdata: [2:0] mode, [34:3] push_value, [39:35] zero
  input  logic [rdq_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: [31:0] front_value, [63:32] back_value, [64] is_empty,
  //          [71:65] entry_count, [72] op_error, [79:73] zero
  input  logic [rdq_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_checked,
  output int                              full_rejects,
  output int                              empty_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  localparam int REPORT_MAX = 10;

  // what the block reports after one operation
  typedef struct {
    logic [DATA_W-1:0]      front;
    logic [DATA_W-1:0]      back;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count;
    logic                   err;
  } deque_view_t;

  // shadow deque state
  logic [DATA_W-1:0] ring [DEPTH];
  logic [SLOT_W-1:0] first_idx;
  logic [SLOT_W-1:0] last_idx;
  int                held;
  bit                flipped;

  deque_view_t expected_views[$];

  int n_mism;
  int n_checked;
  int n_full;
  int n_empty;

  // add a value at the physical first or last end, 1 when full
  function automatic bit store_at_end(bit at_first, logic [DATA_W-1:0] value);
    if (held >= DEPTH) begin
      n_full++;
      return 1'b1;
    end
    if (held == 0) begin
      last_idx = first_idx;
    end else if (at_first) begin
      first_idx = SLOT_W'((int'(first_idx) + DEPTH - 1) % DEPTH);
    end else begin
      last_idx = SLOT_W'((int'(last_idx) + 1) % DEPTH);
    end
    if (at_first) ring[first_idx] = value;
    else ring[last_idx] = value;
    held++;
    return 1'b0;
  endfunction

  // remove at the physical first or last end, 1 when empty
  function automatic bit drop_at_end(bit at_first);
    if (held == 0) begin
      n_empty++;
      return 1'b1;
    end
    // the last entry leaves both slot indices untouched
    if (held > 1) begin
      if (at_first) first_idx = SLOT_W'((int'(first_idx) + 1) % DEPTH);
      else last_idx = SLOT_W'((int'(last_idx) + DEPTH - 1) % DEPTH);
    end
    held--;
    return 1'b0;
  endfunction

  // apply one operation and return the view that follows it
  function automatic deque_view_t apply_op(logic [MODE_W-1:0] mode,
                                           logic [DATA_W-1:0] value);
    deque_view_t v;
    logic        err;
    err = 1'b0;
    case (mode)
      MODE_PUSH_FRONT: err = store_at_end(!flipped, value);
      MODE_PUSH_BACK:  err = store_at_end(flipped, value);
      MODE_POP_FRONT:  err = drop_at_end(!flipped);
      MODE_POP_BACK:   err = drop_at_end(flipped);
      MODE_REVERSE:    flipped = !flipped;
      default: ;
    endcase
    if (held == 0) begin
      v.front = '1;
      v.back  = '1;
    end else if (flipped) begin
      v.front = ring[last_idx];
      v.back  = ring[first_idx];
    end else begin
      v.front = ring[first_idx];
      v.back  = ring[last_idx];
    end
    v.empty = (held == 0);
    v.count = COUNT_OUT_W'(held);
    v.err   = err;
    return v;
  endfunction

  // compare one field, report the first few differences
  function automatic void check_field(string what, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      n_mism++;
      if (n_mism <= REPORT_MAX)
        $display("[%0t] %s mismatch on result %0d: expected %h, got %h",
                 $realtime, what, n_checked, want, got);
    end
  endfunction

  // result side first: a result never belongs to a transaction of the same edge
  always @(posedge clk) begin
    deque_view_t want;
    if (rst) begin
      first_idx = '0;
      last_idx  = '0;
      held      = 0;
      flipped   = 1'b0;
      expected_views.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_views.size() == 0) begin
          n_mism++;
          if (n_mism <= REPORT_MAX)
            $display("[%0t] result with nothing outstanding: %h", $realtime, m_tdata);
        end else begin
          want = expected_views[0];
          expected_views.delete(0);
          check_field("front_value", want.front, m_tdata[31:0]);
          check_field("back_value", want.back, m_tdata[63:32]);
          check_field("is_empty", DATA_W'(want.empty), DATA_W'(m_tdata[64]));
          check_field("entry_count", DATA_W'(want.count), DATA_W'(m_tdata[71:65]));
          check_field("op_error", DATA_W'(want.err), DATA_W'(m_tdata[72]));
          check_field("padding", '0, DATA_W'(m_tdata[OUT_TDATA_W-1:73]));
          n_checked++;
        end
      end
      if (s_tvalid && s_tready)
        expected_views.insert(expected_views.size(),
                              apply_op(s_tdata[MODE_W-1:0],
                                       s_tdata[MODE_W +: DATA_W]));
    end
    outstanding     <= expected_views.size();
    fail_count      <= n_mism;
    results_checked <= n_checked;
    full_rejects    <= n_full;
    empty_rejects   <= n_empty;
  end

endmodule

// File: tb/sv/tb_reversible_deque_unit.sv
// ----------------------------------------------------------------------------
// tb_reversible_deque_unit: regression bench for the reversible deque
// Drives a directed sequence and then fill, drain and mixed bursts of
// operations with random idling and back pressure; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_reversible_deque_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int IDLE_PCT        = 37;
  localparam int RANDOM_ITEMS    = 600;
  localparam int RX_STALL_CYCLES = 250;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;

  // codes outside the defined operations
  localparam int MODE_SPARE_LO = 5;
  localparam int MODE_SPARE_HI = 7;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  bit stall_req = 1'b0;
  bit stall_taken = 1'b0;
  int stall_left = 0;
  bit steady = 1'b0;
  int cycle_count = 0;

  int fail_count;
  int outstanding;
  int results_checked;
  int full_rejects;
  int empty_rejects;

  int n_push = 0;
  int n_pop = 0;
  int n_flip = 0;
  int n_spare = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  reversible_deque_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rdq_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("reversible_deque_unit regression: fail");
      $finish;
    end
  end

  // result side: random back pressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= RX_STALL_CYCLES - 1;
      m_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // offer one operation and wait for its transaction
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({value, mode});
    do @(posedge clk); while (!s_tready);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: n_push++;
      MODE_POP_FRONT, MODE_POP_BACK:   n_pop++;
      MODE_REVERSE:                    n_flip++;
      default:                         n_spare++;
    endcase
  endtask

  // hold the input until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // operation mix by burst kind
  function automatic logic [MODE_W-1:0] pick_op(seg_kind_t kind);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL:  begin push_pct = 82; pop_pct = 6;  end
      SEG_DRAIN: begin push_pct = 6;  pop_pct = 82; end
      default:   begin push_pct = 44; pop_pct = 42; end
    endcase
    if (r < push_pct)
      return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
    if (r < 97)
      return MODE_REVERSE;
    return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endfunction

  // mostly random values, sometimes the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    seg_kind_t kind;
    int        seg;
    int        seg_len;
    int        random_sent;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty errors, extremes, orientation swaps, last-entry pop
    send_op(MODE_POP_FRONT, '1);
    send_op(MODE_POP_BACK, 32'h0000_0001);
    send_op(MODE_REVERSE, '0);
    send_op(MODE_PUSH_FRONT, 32'h8000_0000);
    send_op(MODE_REVERSE, '0);
    send_op(MODE_PUSH_BACK, 32'h7fff_ffff);
    send_op(MODE_PUSH_FRONT, '0);
    send_op(MODE_PUSH_BACK, '1);
    send_op(MODE_REVERSE, 32'h1234_5678);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_PUSH_FRONT, 32'h1234_5678);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_REVERSE, '0);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);
    send_op(MODE_PUSH_BACK, 32'h5a5a_a5a5);
    send_op(MODE_W'(MODE_SPARE_LO), 32'hdead_beef);
    send_op(MODE_W'(MODE_SPARE_LO + 1), '1);
    send_op(MODE_W'(MODE_SPARE_HI), 32'h8000_0000);
    send_op(MODE_POP_FRONT, '0);
    wait_drained();

    // random bursts: fill to full first, then a mix of fill, drain and mixed bursts
    seg = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = seg_kind_t'($urandom_range(0, 2));
      seg_len = $urandom_range(30, 110);
      if (seg <= 1) begin
        kind = SEG_FILL;
        seg_len = 110;
      end
      // the last burst stops at the item budget
      if (seg_len > RANDOM_ITEMS - random_sent) seg_len = RANDOM_ITEMS - random_sent;
      if (seg == 1) stall_req <= 1'b1;
      steady <= (seg == 2);
      repeat (seg_len) begin
        send_op(pick_op(kind), pick_value());
        random_sent++;
      end
      if (seg == 3 || $urandom_range(0, 3) == 0) wait_drained();
      seg++;
    end
    s_tvalid <= 1'b0;

    // let the last results come back
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pushes, %0d pops, %0d reverses and %0d unused codes",
             n_push, n_pop, n_flip, n_spare);
    $display("checked %0d results, %0d pushes on full and %0d pops on empty rejected",
             results_checked, full_rejects, empty_rejects);
    if (fail_count == 0 && outstanding == 0) begin
      $display("reversible_deque_unit regression: pass");
    end else begin
      $display("reversible_deque_unit regression: fail");
    end
    $finish;
  end

endmodule
